/* hw/rtl/kmp_stream_match_counter_macros.svh */
// assertion helpers used by the matcher rtl
`ifndef KMP_STREAM_MATCH_COUNTER_MACROS_SVH
`define KMP_STREAM_MATCH_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge out of reset
`define KSMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen on a clock edge out of reset
`define KSMC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define KSMC_ASSERT(lbl, prop, msg)
`define KSMC_NEVER(lbl, cond, msg)

`endif

`endif

/* hw/rtl/kmpsmc_pkg.sv */
package kmpsmc_pkg;

	// default sizing
	localparam int PATTERN_MAX_DEF = 64;
	localparam int SYMBOL_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF  = 32;

	// fixed field widths on the stream ports
	localparam int OP_W        = 2;
	localparam int SYM_FIELD_W = 8;
	localparam int CNT_FIELD_W = 32;
	localparam int PRG_FIELD_W = 7;
	localparam int OUT_DATA_W  = 40;
	localparam int IN_DATA_W   = 8;

	// request kinds
	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 2'd0,
		OP_TEXT     = 2'd1,
		OP_CLR_TEXT = 2'd2,
		OP_CLR_PAT  = 2'd3
	} op_t;

endpackage

/* hw/rtl/kmpsmc_ram.sv */
module kmpsmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/kmp_stream_match_counter.sv */
// Streaming Knuth-Morris-Pratt matcher with a saturating occurrence counter.
// Input channel s_*: s_tuser carries the op (append pattern byte, text byte,
// clear text state and count, clear pattern), s_tdata carries the byte.
// Output channel m_*: exactly one result per request. m_tuser is the match
// flag, m_tdata carries the occurrence count and the matched prefix length.
// Pattern bytes and their border (failure) lengths live in two RAMs with a
// registered read; a request is accepted in S_IDLE and finished in S_STEP,
// which repeats for each failure link that is followed and while the
// receiver stalls a full output register. Links are walked one RAM read per cycle;
// over a text stream the walk averages under one step per byte. The matcher
// finishes one request before it takes the next.
// A new request is taken whenever the matcher is idle, even while the last
// result still sits in the output register. If the receiver stalls, the next
// result waits in the finishing cycle and no further request is accepted.
// Reset clears pattern length, match progress and count; no RAM clearing
// pass is needed since only written entries are ever used.
`include "kmp_stream_match_counter_macros.svh"

module kmp_stream_match_counter #(
	parameter int PATTERN_MAX = kmpsmc_pkg::PATTERN_MAX_DEF,
	parameter int SYMBOL_BITS = kmpsmc_pkg::SYMBOL_BITS_DEF,
	parameter int COUNT_BITS  = kmpsmc_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [kmpsmc_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] symbol
	input  logic [kmpsmc_pkg::OP_W-1:0]       s_tuser,  // [1:0] op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [kmpsmc_pkg::OUT_DATA_W-1:0] m_tdata,  // [31:0] match_count, [38:32] match_progress
	output logic                              m_tuser   // [0] match
);

	import kmpsmc_pkg::*;

	localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int PROG_W = $clog2(PATTERN_MAX + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_STEP = 2'b10
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [PROG_W-1:0]      j_q;
	logic [PROG_W-1:0]      len_q;
	logic [IDX_W-1:0]       bb_q;
	logic [PROG_W-1:0]      prog_q;
	logic [COUNT_BITS-1:0]  cnt_q;

	logic                   out_valid_q;
	logic                   out_match_q;
	logic [CNT_FIELD_W-1:0] out_count_q;
	logic [PRG_FIELD_W-1:0] out_prog_q;

	logic                   accept;
	logic                   out_free;
	op_t                    op_in;
	logic [PROG_W-1:0]      start_j;
	logic [PROG_W-1:0]      walk_j;
	logic [PROG_W-1:0]      walk_jm1;
	logic                   rd_en;
	logic [SYMBOL_BITS-1:0] pat_rd;
	logic [IDX_W-1:0]       bor_rd;
	logic                   active;
	logic                   need_walk;
	logic                   ext;
	logic [PROG_W-1:0]      j_next;
	logic                   hit;
	logic                   commit;
	logic                   len_room;
	logic                   wr_en;
	logic [IDX_W-1:0]       new_border;
	logic [PROG_W-1:0]      len_next;
	logic [IDX_W-1:0]       bb_next;
	logic [PROG_W-1:0]      prog_next;
	logic [COUNT_BITS-1:0]  cnt_next;

	// handshake
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign op_in    = op_t'(s_tuser);
	assign len_room = (len_q < PROG_W'(PATTERN_MAX));

	// starting prefix length for the link walk
	always_comb begin
		if (op_in == OP_APPEND) begin
			start_j = PROG_W'(bb_q);
		end else if (prog_q >= len_q) begin
			start_j = '0;
		end else begin
			start_j = prog_q;
		end
	end

	// read address: start on accept, follow a link while walking
	assign walk_j   = (state_q == S_IDLE) ? start_j : PROG_W'(bor_rd);
	assign walk_jm1 = walk_j - PROG_W'(1);
	assign rd_en    = accept || ((state_q == S_STEP) && need_walk);

	// compare against pattern[j], decide whether to follow border[j-1]
	assign active = ((op_q == OP_APPEND) && (len_q != '0) && len_room)
		|| ((op_q == OP_TEXT) && (len_q != '0));
	assign need_walk = active && (j_q != '0) && (sym_q != pat_rd);
	assign ext       = active && (j_q < len_q) && (sym_q == pat_rd);
	assign j_next    = j_q + PROG_W'(ext);
	assign hit       = (op_q == OP_TEXT) && (len_q != '0) && (j_next == len_q);
	assign commit    = (state_q == S_STEP) && !need_walk && out_free;

	// pattern append write-back
	assign wr_en      = commit && (op_q == OP_APPEND) && len_room;
	assign new_border = (len_q == '0) ? '0 : j_next[IDX_W-1:0];

	// next architectural state for the finishing request
	always_comb begin
		len_next  = len_q;
		bb_next   = bb_q;
		prog_next = prog_q;
		cnt_next  = cnt_q;
		case (op_q)
			OP_APPEND: begin
				if (len_room) begin
					len_next = len_q + PROG_W'(1);
					bb_next  = new_border;
				end
			end
			OP_TEXT: begin
				if (len_q == '0) begin
					prog_next = '0;
				end else if (hit) begin
					prog_next = PROG_W'(bb_q);
					if (cnt_q != {COUNT_BITS{1'b1}}) begin
						cnt_next = cnt_q + COUNT_BITS'(1);
					end
				end else begin
					prog_next = j_next;
				end
			end
			OP_CLR_TEXT: begin
				prog_next = '0;
				cnt_next  = '0;
			end
			OP_CLR_PAT: begin
				len_next  = '0;
				bb_next   = '0;
				prog_next = '0;
			end
			default: begin
				prog_next = prog_q;
			end
		endcase
	end

	// pattern bytes
	kmpsmc_ram #(
		.WIDTH(SYMBOL_BITS),
		.DEPTH(PATTERN_MAX),
		.AW   (IDX_W)
	) u_pat_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[IDX_W-1:0]),
		.wdata(sym_q),
		.re   (rd_en),
		.raddr(walk_j[IDX_W-1:0]),
		.rdata(pat_rd)
	);

	// border length of each pattern prefix
	kmpsmc_ram #(
		.WIDTH(IDX_W),
		.DEPTH(PATTERN_MAX),
		.AW   (IDX_W)
	) u_bor_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(len_q[IDX_W-1:0]),
		.wdata(new_border),
		.re   (rd_en),
		.raddr(walk_jm1[IDX_W-1:0]),
		.rdata(bor_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			bb_q        <= '0;
			prog_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				len_q  <= len_next;
				bb_q   <= bb_next;
				prog_q <= prog_next;
				cnt_q  <= cnt_next;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and walk index
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			sym_q <= SYMBOL_BITS'(s_tdata[SYM_FIELD_W-1:0]);
		end
		if (rd_en) begin
			j_q <= walk_j;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			out_match_q <= hit;
			out_count_q <= CNT_FIELD_W'(cnt_next);
			out_prog_q  <= PRG_FIELD_W'(prog_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_match_q;
	assign m_tdata  = {{(OUT_DATA_W - CNT_FIELD_W - PRG_FIELD_W){1'b0}}, out_prog_q, out_count_q};

	`KSMC_ASSERT(a_prog_below_len, (len_q == '0) ? (prog_q == '0) : (prog_q < len_q), "progress reached pattern length")
	`KSMC_ASSERT(a_border_below_len, (len_q == '0) ? (bb_q == '0) : (PROG_W'(bb_q) < len_q), "border not below pattern length")
	`KSMC_ASSERT(a_walk_in_range, ((state_q == S_STEP) && active) |-> (j_q < len_q), "walk index left the stored pattern")
	`KSMC_NEVER(a_count_drop, (cnt_q < $past(cnt_q)) && !$past(commit && (op_q == OP_CLR_TEXT)), "count fell without a clear")

endmodule
